/* hdl/hid_report_descriptor_parser_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_MACROS_SVH

// Same-cycle implication, held off during reset
`define HRDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset
`define HRDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/hrdp_pkg.sv */
// Shared types, codes and helpers of the HID report descriptor parser.
package hrdp_pkg;

  // Default depth of the local usage list
  localparam int unsigned MAX_USAGES = 32;

  // Result item width, packed and padded to whole bytes
  localparam int unsigned OUT_W = 168;

  // Short-item type codes (prefix bits 3:2)
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // Tags (prefix bits 7:4)
  localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
  localparam logic [3:0] TAG_LOGICAL_MAX = 4'h2;
  localparam logic [3:0] TAG_REPORT_SIZE = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
  localparam logic [3:0] TAG_USAGE = 4'h0;
  localparam logic [3:0] TAG_INPUT = 4'h8;

  // Usage pages and usages of interest
  localparam logic [31:0] PAGE_DESKTOP   = 32'h01;
  localparam logic [31:0] PAGE_KEYBOARD  = 32'h07;
  localparam logic [31:0] PAGE_BUTTON    = 32'h09;
  localparam logic [31:0] PAGE_DIGITIZER = 32'h0D;
  localparam logic [15:0] USAGE_X        = 16'h30;
  localparam logic [15:0] USAGE_Y        = 16'h31;
  localparam logic [15:0] USAGE_TIP      = 16'h42;
  localparam logic [15:0] USAGE_BUTTON1  = 16'h01;

  // One complete (or truncated) short item
  typedef struct packed {
    logic [7:0]  prefix;
    logic [31:0] data;
  } item_t;

  // Data byte count from the size code
  function automatic logic [2:0] item_len(input logic [7:0] p);
    item_len = (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
  endfunction

  // Clamp a 32-bit value to 16 bits
  function automatic logic [15:0] sat16_32(input logic [31:0] v);
    sat16_32 = (v[31:16] != 16'h0) ? 16'hFFFF : v[15:0];
  endfunction

  // Clamp a 17-bit sum to 16 bits
  function automatic logic [15:0] sat16_17(input logic [16:0] v);
    sat16_17 = v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* hdl/hrdp_usage_mem.sv */
// Local usage list: one write port, one registered read port.
module hrdp_usage_mem #(
  parameter int unsigned DEPTH  = hrdp_pkg::MAX_USAGES,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/hrdp_item_asm.sv */
// Short-item assembler: gathers prefix and little-endian data bytes.
module hrdp_item_asm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          desc_byte,
  input  logic                first,
  input  logic                last,
  output logic                done,
  output hrdp_pkg::item_t     item
);

  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  left_r, left_nxt;

  logic [7:0]  base_prefix;
  logic [31:0] base_accum;
  logic [2:0]  base_left;
  logic [2:0]  k;
  logic [2:0]  left_calc;

  // first clears the item state before the byte is used
  always_comb begin
    base_prefix = first ? 8'h0 : prefix_r;
    base_accum  = first ? 32'h0 : accum_r;
    base_left   = first ? 3'd0 : left_r;
    k           = hrdp_pkg::item_len(base_prefix) - base_left;
    prefix_nxt  = prefix_r;
    accum_nxt   = accum_r;
    left_nxt    = left_r;
    left_calc   = left_r;
    done        = 1'b0;
    if (acc) begin
      if (base_left == 3'd0) begin
        prefix_nxt = desc_byte;
        accum_nxt  = 32'h0;
        left_calc  = hrdp_pkg::item_len(desc_byte);
      end else begin
        prefix_nxt = base_prefix;
        accum_nxt  = base_accum | ({24'h0, desc_byte} << {k[1:0], 3'b000});
        left_calc  = base_left - 3'd1;
      end
      // a last byte inside an item finishes it with what has arrived
      done     = (left_calc == 3'd0) || last;
      left_nxt = last ? 3'd0 : left_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 8'h0;
      accum_r  <= 32'h0;
      left_r   <= 3'd0;
    end else begin
      prefix_r <= prefix_nxt;
      accum_r  <= accum_nxt;
      left_r   <= left_nxt;
    end
  end

  assign item.prefix = prefix_r;
  assign item.data   = accum_r;

endmodule

/* hdl/hid_report_descriptor_parser.sv */
// HID report descriptor parser: top level with item control and field scan.
//
// Input channel (in_*): one descriptor byte per transfer. in_tuser marks the
// first byte and clears all parse state; in_tlast marks the final byte.
// Result channel (out_*): one item after each in_tlast byte, with the
// pointer X/Y/tip field positions and the keyboard report ID.
// A byte that does not complete an item is taken in S_IDLE alone. A byte
// that completes any item but an Input item passes S_IDLE and
// S_EXEC. A byte that completes an Input item also runs S_SCAN over N =
// min(usages + 1, report count) <= MAX_USAGES + 1 fields: the scan reads one usage
// per cycle from the read port of the usage memory; the read data is
// registered before the check, and the bit position is updated last.
// The result is loaded in S_EMIT after the last item completes and sits in an
// output register until taken; parsing of further bytes goes on meanwhile.
// A second result waiting on a stalled receiver holds off the input.
// Reset clears all parse state; the usage memory needs no clearing, since
// only written entries are ever used.
`include "hid_report_descriptor_parser_macros.svh"

module hid_report_descriptor_parser #(
  parameter int unsigned MAX_USAGES = hrdp_pkg::MAX_USAGES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // desc_byte
  input  logic                       in_tuser,   // first
  input  logic                       in_tlast,   // last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // parsed, x_offset, x_size, x_logical_max, y_offset, y_size,
  // y_logical_max, tip_offset, pointer_report_id, is_keyboard,
  // keyboard_report_id, zero pad
  output logic [hrdp_pkg::OUT_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_USAGES + 1);
  localparam int unsigned LIM_W = $clog2(MAX_USAGES + 2);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_EMIT} state_t;

  state_t state_r, state_nxt;

  logic              acc;
  logic              clr;
  logic              item_done;
  hrdp_pkg::item_t   itm;
  logic [1:0]        itm_type;
  logic [3:0]        itm_tag;

  // globals and list fill
  logic [31:0]      page_r, page_nxt;
  logic [31:0]      lmax_r, lmax_nxt;
  logic [15:0]      rsize_r, rsize_nxt;
  logic [15:0]      rcount_r, rcount_nxt;
  logic [7:0]       rid_r, rid_nxt;
  logic [15:0]      bitpos_r, bitpos_nxt;
  logic [CNT_W-1:0] ucount_r, ucount_nxt;

  // found fields
  logic        fx_found_r, fx_found_nxt;
  logic [15:0] fx_off_r, fx_off_nxt;
  logic [15:0] fx_size_r, fx_size_nxt;
  logic [31:0] fx_lmax_r, fx_lmax_nxt;
  logic [7:0]  ptr_id_r, ptr_id_nxt;
  logic        fy_found_r, fy_found_nxt;
  logic [15:0] fy_off_r, fy_off_nxt;
  logic [15:0] fy_size_r, fy_size_nxt;
  logic [31:0] fy_lmax_r, fy_lmax_nxt;
  logic        ft_found_r, ft_found_nxt;
  logic [15:0] ft_off_r, ft_off_nxt;
  logic        kbd_r, kbd_nxt;
  logic [7:0]  kbd_id_r, kbd_id_nxt;

  // scan control
  logic             last_r, last_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [LIM_W-1:0] rd_f_r, rd_f_nxt;
  logic             vld_r, vld_nxt;
  logic [15:0]      fpos_r, fpos_nxt;
  logic [31:0]      prod_r, prod_nxt;

  // result register
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [hrdp_pkg::OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  // memory ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  // scan datapath
  logic [LIM_W-1:0] cnt_p1;
  logic [15:0]      use_u;
  logic [15:0]      fld_off;
  logic             desktop;
  logic             is_tip;
  logic [16:0]      x_off17, y_off17, t_off17;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign clr       = acc && in_tuser;
  assign itm_type  = itm.prefix[3:2];
  assign itm_tag   = itm.prefix[7:4];

  hrdp_item_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .desc_byte (in_tdata),
    .first     (in_tuser),
    .last      (in_tlast),
    .done      (item_done),
    .item      (itm)
  );

  hrdp_usage_mem #(
    .DEPTH  (MAX_USAGES),
    .WIDTH  (16),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (itm.data[15:0]),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory addressing: past the list, reuse the last entry
  assign mem_we    = (state_r == S_EXEC) && (itm_type == hrdp_pkg::TYPE_LOCAL) &&
                     (itm_tag == hrdp_pkg::TAG_USAGE) &&
                     (ucount_r < CNT_W'(MAX_USAGES));
  assign mem_waddr = IDX_W'(ucount_r);
  assign mem_raddr = (rd_f_r < LIM_W'(ucount_r)) ? rd_f_r[IDX_W-1:0]
                                                 : IDX_W'(ucount_r - CNT_W'(1));

  // field check stage
  assign cnt_p1  = LIM_W'(ucount_r) + LIM_W'(1);
  assign use_u   = (ucount_r == '0) ? 16'h0 : mem_rdata;
  assign fld_off = hrdp_pkg::sat16_17({1'b0, bitpos_r} + {1'b0, fpos_r});
  assign desktop = (page_r == hrdp_pkg::PAGE_DESKTOP);
  assign is_tip  = ((page_r == hrdp_pkg::PAGE_DIGITIZER) && (use_u == hrdp_pkg::USAGE_TIP)) ||
                   ((page_r == hrdp_pkg::PAGE_BUTTON) && (use_u == hrdp_pkg::USAGE_BUTTON1));

  // result offsets, all ones when not found
  assign x_off17 = fx_found_r ? {1'b0, fx_off_r} : 17'h1FFFF;
  assign y_off17 = fy_found_r ? {1'b0, fy_off_r} : 17'h1FFFF;
  assign t_off17 = ft_found_r ? {1'b0, ft_off_r} : 17'h1FFFF;

  // next-state logic
  always_comb begin
    state_nxt    = state_r;
    page_nxt     = page_r;
    lmax_nxt     = lmax_r;
    rsize_nxt    = rsize_r;
    rcount_nxt   = rcount_r;
    rid_nxt      = rid_r;
    bitpos_nxt   = bitpos_r;
    ucount_nxt   = ucount_r;
    fx_found_nxt = fx_found_r;
    fx_off_nxt   = fx_off_r;
    fx_size_nxt  = fx_size_r;
    fx_lmax_nxt  = fx_lmax_r;
    ptr_id_nxt   = ptr_id_r;
    fy_found_nxt = fy_found_r;
    fy_off_nxt   = fy_off_r;
    fy_size_nxt  = fy_size_r;
    fy_lmax_nxt  = fy_lmax_r;
    ft_found_nxt = ft_found_r;
    ft_off_nxt   = ft_off_r;
    kbd_nxt      = kbd_r;
    kbd_id_nxt   = kbd_id_r;
    last_nxt     = last_r;
    lim_nxt      = lim_r;
    rd_f_nxt     = rd_f_r;
    vld_nxt      = 1'b0;
    fpos_nxt     = fpos_r;
    prod_nxt     = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    unique case (state_r)
      // take a byte; clear everything on a first byte
      S_IDLE: begin
        if (acc) begin
          if (clr) begin
            page_nxt     = '0;
            lmax_nxt     = '0;
            rsize_nxt    = '0;
            rcount_nxt   = '0;
            rid_nxt      = '0;
            bitpos_nxt   = '0;
            ucount_nxt   = '0;
            fx_found_nxt = 1'b0;
            fy_found_nxt = 1'b0;
            ft_found_nxt = 1'b0;
            kbd_nxt      = 1'b0;
          end
          last_nxt = in_tlast;
          if (item_done) begin
            state_nxt = S_EXEC;
          end
        end
      end

      // run the completed item
      S_EXEC: begin
        state_nxt = last_r ? S_EMIT : S_IDLE;
        unique case (itm_type)
          hrdp_pkg::TYPE_GLOBAL: begin
            unique case (itm_tag)
              hrdp_pkg::TAG_USAGE_PAGE:   page_nxt = itm.data;
              hrdp_pkg::TAG_LOGICAL_MAX:  lmax_nxt = itm.data;
              hrdp_pkg::TAG_REPORT_SIZE:  rsize_nxt = hrdp_pkg::sat16_32(itm.data);
              hrdp_pkg::TAG_REPORT_COUNT: rcount_nxt = hrdp_pkg::sat16_32(itm.data);
              hrdp_pkg::TAG_REPORT_ID: begin
                rid_nxt    = itm.data[7:0];
                bitpos_nxt = '0;
              end
              default: ;
            endcase
          end
          hrdp_pkg::TYPE_LOCAL: begin
            if (mem_we) begin
              ucount_nxt = ucount_r + CNT_W'(1);
            end
          end
          hrdp_pkg::TYPE_MAIN: begin
            ucount_nxt = '0;
            if (itm_tag == hrdp_pkg::TAG_INPUT) begin
              ucount_nxt = ucount_r;
              state_nxt  = S_SCAN;
              if ((page_r == hrdp_pkg::PAGE_KEYBOARD) && !kbd_r) begin
                kbd_nxt    = 1'b1;
                kbd_id_nxt = rid_r;
              end
              lim_nxt  = ({1'b0, rcount_r} < 17'(cnt_p1)) ? LIM_W'(rcount_r) : cnt_p1;
              rd_f_nxt = '0;
              fpos_nxt = '0;
              prod_nxt = rsize_r * rcount_r;
            end
          end
          default: ;
        endcase
      end

      // one usage read per cycle, checked in the cycle after its read
      S_SCAN: begin
        if (rd_f_r < lim_r) begin
          rd_f_nxt = rd_f_r + LIM_W'(1);
          vld_nxt  = 1'b1;
        end
        if (vld_r) begin
          fpos_nxt = hrdp_pkg::sat16_17({1'b0, fpos_r} + {1'b0, rsize_r});
          priority if (desktop && (use_u == hrdp_pkg::USAGE_X) && !fx_found_r) begin
            fx_found_nxt = 1'b1;
            fx_off_nxt   = fld_off;
            fx_size_nxt  = rsize_r;
            fx_lmax_nxt  = lmax_r;
            ptr_id_nxt   = rid_r;
          end else if (desktop && (use_u == hrdp_pkg::USAGE_Y) && !fy_found_r) begin
            fy_found_nxt = 1'b1;
            fy_off_nxt   = fld_off;
            fy_size_nxt  = rsize_r;
            fy_lmax_nxt  = lmax_r;
          end else if (is_tip && !ft_found_r) begin
            ft_found_nxt = 1'b1;
            ft_off_nxt   = fld_off;
          end else begin
          end
        end else if (rd_f_r == lim_r) begin
          bitpos_nxt = hrdp_pkg::sat16_17({1'b0, bitpos_r} +
                                          {1'b0, hrdp_pkg::sat16_32(prod_r)});
          ucount_nxt = '0;
          state_nxt  = last_r ? S_EMIT : S_IDLE;
        end
      end

      // load the result once the output register is free
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000,
                            kbd_r ? kbd_id_r : 8'h0,
                            kbd_r,
                            fx_found_r ? ptr_id_r : 8'h0,
                            t_off17,
                            fy_found_r ? fy_lmax_r : 32'h0,
                            fy_found_r ? fy_size_r : 16'h0,
                            y_off17,
                            fx_found_r ? fx_lmax_r : 32'h0,
                            fx_found_r ? fx_size_r : 16'h0,
                            x_off17,
                            fx_found_r && fy_found_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_r       <= '0;
      lmax_r       <= '0;
      rsize_r      <= '0;
      rcount_r     <= '0;
      rid_r        <= '0;
      bitpos_r     <= '0;
      ucount_r     <= '0;
      fx_found_r   <= 1'b0;
      fy_found_r   <= 1'b0;
      ft_found_r   <= 1'b0;
      kbd_r        <= 1'b0;
      last_r       <= 1'b0;
      lim_r        <= '0;
      rd_f_r       <= '0;
      vld_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_r       <= page_nxt;
      lmax_r       <= lmax_nxt;
      rsize_r      <= rsize_nxt;
      rcount_r     <= rcount_nxt;
      rid_r        <= rid_nxt;
      bitpos_r     <= bitpos_nxt;
      ucount_r     <= ucount_nxt;
      fx_found_r   <= fx_found_nxt;
      fy_found_r   <= fy_found_nxt;
      ft_found_r   <= ft_found_nxt;
      kbd_r        <= kbd_nxt;
      last_r       <= last_nxt;
      lim_r        <= lim_nxt;
      rd_f_r       <= rd_f_nxt;
      vld_r        <= vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fx_off_r    <= fx_off_nxt;
    fx_size_r   <= fx_size_nxt;
    fx_lmax_r   <= fx_lmax_nxt;
    ptr_id_r    <= ptr_id_nxt;
    fy_off_r    <= fy_off_nxt;
    fy_size_r   <= fy_size_nxt;
    fy_lmax_r   <= fy_lmax_nxt;
    ft_off_r    <= ft_off_nxt;
    kbd_id_r    <= kbd_id_nxt;
    fpos_r      <= fpos_nxt;
    prod_r      <= prod_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `HRDP_ASSERT_NEXT(a_done_runs_item, acc && item_done, state_r == S_EXEC, "completed item not run")
  `HRDP_ASSERT_NOW(a_scan_bound, state_r == S_SCAN, rd_f_r <= lim_r, "scan ran past its field limit")
  `HRDP_ASSERT_NOW(a_list_bound, 1'b1, ucount_r <= CNT_W'(MAX_USAGES), "usage count overflow")
  `HRDP_ASSERT_NOW(a_chk_in_scan, vld_r, state_r == S_SCAN, "field check outside a scan")

endmodule

/* verif/tb.sv */
// Testbench for the HID report descriptor parser: directed and random descriptors.
module tb;
  import hrdp_pkg::*;

  // Item codes the package leaves out
  localparam logic [1:0] TYPE_RESERVED      = 2'd3;
  localparam logic [3:0] TAG_OUTPUT         = 4'h9;
  localparam logic [3:0] TAG_COLLECTION     = 4'hA;
  localparam logic [3:0] TAG_FEATURE        = 4'hB;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
  localparam logic [3:0] TAG_LONG           = 4'hF;

  localparam logic [16:0] NO_FIELD     = 17'h1FFFF;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Result item, fields from the top bit down
  typedef struct packed {
    logic [2:0]  pad;
    logic [7:0]  kbd_id;
    logic        kbd;
    logic [7:0]  ptr_id;
    logic [16:0] tip_off;
    logic [31:0] y_lmax;
    logic [15:0] y_size;
    logic [16:0] y_off;
    logic [31:0] x_lmax;
    logic [15:0] x_size;
    logic [16:0] x_off;
    logic        parsed;
  } layout_t;

  // One row of the directed table
  typedef struct {
    logic [7:0] b;
    logic       f;
    logic       l;
    bit         lit;
    layout_t    res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  hid_report_descriptor_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser shadow state
  logic [7:0]  cur_prefix;
  logic [31:0] acc_data;
  int unsigned bytes_due;
  logic [31:0] page_reg;
  logic [31:0] lmax_reg;
  logic [15:0] rsize_reg;
  logic [15:0] rcount_reg;
  logic [7:0]  rid_reg;
  logic [15:0] bitpos_reg;
  logic [15:0] usages [MAX_USAGES];
  int unsigned n_usages;

  // Fields located so far
  bit          x_hit, y_hit, tip_hit, kbd_hit;
  logic [15:0] x_pos, x_bits, y_pos, y_bits, tip_pos;
  logic [31:0] x_lmax, y_lmax;
  logic [7:0]  x_rid, kbd_rid;

  layout_t     expected_layouts[$];
  step_t       directed_steps[$];
  logic [7:0]  desc_bytes[$];
  int unsigned tail_len;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_pct = 20;
  int unsigned rx_hold = 0;
  bit          idle_on = 1'b1;

  function automatic logic [7:0] pfx(input logic [3:0] tag, input logic [1:0] typ,
                                     input logic [1:0] sz);
    return {tag, typ, sz};
  endfunction

  function automatic int unsigned data_len(input logic [7:0] p);
    return (p[1:0] == 2'd3) ? 4 : p[1:0];
  endfunction

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic layout_t layout_of(input logic parsed, input logic [16:0] xo,
                                        input logic [15:0] xs, input logic [31:0] xl,
                                        input logic [16:0] yo, input logic [15:0] ys,
                                        input logic [31:0] yl, input logic [16:0] to,
                                        input logic [7:0] pid, input logic kb,
                                        input logic [7:0] kid);
    layout_t r;
    r = '0;
    r.parsed = parsed; r.x_off = xo; r.x_size = xs; r.x_lmax = xl;
    r.y_off = yo; r.y_size = ys; r.y_lmax = yl; r.tip_off = to;
    r.ptr_id = pid; r.kbd = kb; r.kbd_id = kid;
    return r;
  endfunction

  function automatic void clear_parse();
    cur_prefix = '0; acc_data = '0; bytes_due = 0;
    page_reg = '0; lmax_reg = '0; rsize_reg = '0; rcount_reg = '0;
    rid_reg = '0; bitpos_reg = '0; n_usages = 0;
    x_hit = 0; y_hit = 0; tip_hit = 0; kbd_hit = 0;
    x_pos = '0; x_bits = '0; y_pos = '0; y_bits = '0; tip_pos = '0;
    x_lmax = '0; y_lmax = '0; x_rid = '0; kbd_rid = '0;
  endfunction

  // Execute the completed (or cut short) item in cur_prefix/acc_data
  function automatic void apply_item();
    logic [1:0]  typ;
    logic [3:0]  tag;
    logic [15:0] u;
    logic [15:0] pos;
    int unsigned lim;
    int unsigned i;
    typ = cur_prefix[3:2];
    tag = cur_prefix[7:4];
    case (typ)
      TYPE_GLOBAL: begin
        case (tag)
          TAG_USAGE_PAGE:   page_reg = acc_data;
          TAG_LOGICAL_MAX:  lmax_reg = acc_data;
          TAG_REPORT_SIZE:  rsize_reg = clamp16(acc_data);
          TAG_REPORT_ID: begin
            rid_reg = acc_data[7:0];
            bitpos_reg = '0;
          end
          TAG_REPORT_COUNT: rcount_reg = clamp16(acc_data);
          default: ;
        endcase
      end
      TYPE_LOCAL: begin
        if (tag == TAG_USAGE && n_usages < MAX_USAGES) begin
          usages[n_usages] = acc_data[15:0];
          n_usages++;
        end
      end
      TYPE_MAIN: begin
        if (tag == TAG_INPUT) begin
          if (page_reg == PAGE_KEYBOARD && !kbd_hit) begin
            kbd_hit = 1;
            kbd_rid = rid_reg;
          end
          // past the list every field repeats the last usage, so one extra probe
          lim = n_usages + 1;
          if (lim > rcount_reg) lim = rcount_reg;
          for (i = 0; i < lim; i++) begin
            if (i < n_usages) u = usages[i];
            else u = (n_usages != 0) ? usages[n_usages - 1] : 16'h0000;
            pos = clamp16({16'h0, bitpos_reg} + {16'h0, clamp16(i * {16'h0, rsize_reg})});
            if (page_reg == PAGE_DESKTOP && u == USAGE_X && !x_hit) begin
              x_hit = 1; x_pos = pos; x_bits = rsize_reg; x_lmax = lmax_reg;
              x_rid = rid_reg;
            end else if (page_reg == PAGE_DESKTOP && u == USAGE_Y && !y_hit) begin
              y_hit = 1; y_pos = pos; y_bits = rsize_reg; y_lmax = lmax_reg;
            end else if (((page_reg == PAGE_DIGITIZER && u == USAGE_TIP) ||
                          (page_reg == PAGE_BUTTON && u == USAGE_BUTTON1)) && !tip_hit) begin
              tip_hit = 1; tip_pos = pos;
            end
          end
          bitpos_reg = clamp16({16'h0, bitpos_reg} +
                               {16'h0, clamp16({16'h0, rsize_reg} * {16'h0, rcount_reg})});
        end
        n_usages = 0;
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow parser by one byte; returns 1 with the layout on a final byte
  function automatic bit parse_byte(input logic [7:0] b, input logic f, input logic l,
                                    output layout_t lay);
    lay = '0;
    if (f) clear_parse();
    if (bytes_due == 0) begin
      cur_prefix = b;
      acc_data = '0;
      bytes_due = data_len(b);
      if (bytes_due == 0) apply_item();
    end else begin
      acc_data[8 * (data_len(cur_prefix) - bytes_due) +: 8] = b;
      bytes_due--;
      if (bytes_due == 0) apply_item();
    end
    if (!l) return 1'b0;
    // final byte cuts a pending item short, missing bytes read as zero
    if (bytes_due != 0) begin
      bytes_due = 0;
      apply_item();
    end
    lay = layout_of(x_hit && y_hit,
                    x_hit ? {1'b0, x_pos} : NO_FIELD, x_hit ? x_bits : 16'h0,
                    x_hit ? x_lmax : 32'h0,
                    y_hit ? {1'b0, y_pos} : NO_FIELD, y_hit ? y_bits : 16'h0,
                    y_hit ? y_lmax : 32'h0,
                    tip_hit ? {1'b0, tip_pos} : NO_FIELD,
                    x_hit ? x_rid : 8'h0, kbd_hit, kbd_hit ? kbd_rid : 8'h0);
    return 1'b1;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) flag($sformatf("%s expected %h got %h", name, want, got));
  endtask

  task automatic check_layout(input layout_t got);
    layout_t want;
    if (expected_layouts.size() == 0) begin
      flag($sformatf("result with none pending: %h", got));
    end else begin
      want = expected_layouts.pop_front();
      cmp("parsed", want.parsed, got.parsed);
      cmp("x_offset", want.x_off, got.x_off);
      cmp("x_size", want.x_size, got.x_size);
      cmp("x_logical_max", want.x_lmax, got.x_lmax);
      cmp("y_offset", want.y_off, got.y_off);
      cmp("y_size", want.y_size, got.y_size);
      cmp("y_logical_max", want.y_lmax, got.y_lmax);
      cmp("tip_offset", want.tip_off, got.tip_off);
      cmp("pointer_report_id", want.ptr_id, got.ptr_id);
      cmp("is_keyboard", want.kbd, got.kbd);
      cmp("keyboard_report_id", want.kbd_id, got.kbd_id);
      cmp("pad", want.pad, got.pad);
    end
  endtask

  // Result side: check taken items, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_layout(out_tdata);
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        rx_hold <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL hid_report_descriptor_parser");
      $finish;
    end
  end

  // Drive one byte, wait for the handshake, then predict
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                           input bit use_lit, input layout_t lit);
    layout_t lay;
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, f, l, lay)) expected_layouts.push_back(use_lit ? lit : lay);
  endtask

  task automatic plan_row(input logic [7:0] b, input logic f, input logic l,
                          input bit lit = 1'b0, input layout_t res = '0);
    step_t s;
    s.b = b; s.f = f; s.l = l; s.lit = lit; s.res = res;
    directed_steps.push_back(s);
  endtask

  // Append one short item; size code fits the value unless any is allowed
  task automatic put_item(input logic [3:0] tag, input logic [1:0] typ,
                          input logic [31:0] v, input bit any_size);
    logic [1:0]  sz;
    int unsigned n;
    int unsigned k;
    if (any_size) sz = $urandom_range(0, 3);
    else if (v[31:16] != 0) sz = 2'd3;
    else if (v[15:8] != 0) sz = 2'd2;
    else if (v[7:0] != 0) sz = 2'd1;
    else sz = $urandom_range(0, 1);
    n = data_len({6'h0, sz});
    desc_bytes.push_back(pfx(tag, typ, sz));
    for (k = 0; k < n; k++) desc_bytes.push_back(v[8 * k +: 8]);
    tail_len = n;
  endtask

  function automatic logic [31:0] pick_page();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PAGE_DESKTOP;
      4:          return PAGE_KEYBOARD;
      5:          return PAGE_BUTTON;
      6:          return PAGE_DIGITIZER;
      7:          return {16'h0001, PAGE_DESKTOP[15:0]};
      8:          return $urandom();
      default:    return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [31:0] pick_usage();
    case ($urandom_range(0, 9))
      0, 1, 2: return {16'h0, USAGE_X};
      3, 4, 5: return {16'h0, USAGE_Y};
      6:       return {16'h0, USAGE_TIP};
      7:       return {16'h0, USAGE_BUTTON1};
      8:       return {16'($urandom()), $urandom_range(0, 1) ? USAGE_X : USAGE_Y};
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 8);
      6, 7:             return $urandom_range(9, 40);
      8:                return $urandom_range(0, 65535);
      default:          return $urandom();
    endcase
  endfunction

  // Random descriptor, mostly well-formed, into desc_bytes
  task automatic build_descriptor();
    int unsigned kind;
    desc_bytes.delete();
    tail_len = 0;
    if ($urandom_range(0, 9) < 6) begin
      put_item(TAG_USAGE_PAGE, TYPE_GLOBAL, PAGE_DESKTOP, 1'b0);
      if ($urandom_range(0, 1)) put_item(TAG_REPORT_ID, TYPE_GLOBAL, $urandom_range(0, 255), 1'b0);
    end
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(0, 99);
      if (kind < 14) put_item(TAG_USAGE_PAGE, TYPE_GLOBAL, pick_page(), $urandom_range(0, 7) == 0);
      else if (kind < 38) put_item(TAG_USAGE, TYPE_LOCAL, pick_usage(), $urandom_range(0, 7) == 0);
      else if (kind < 52) put_item(TAG_INPUT, TYPE_MAIN, $urandom_range(0, 255), 1'b0);
      else if (kind < 61) put_item(TAG_REPORT_SIZE, TYPE_GLOBAL, pick_count(), 1'b0);
      else if (kind < 70) put_item(TAG_REPORT_COUNT, TYPE_GLOBAL, pick_count(), 1'b0);
      else if (kind < 77) put_item(TAG_LOGICAL_MAX, TYPE_GLOBAL, $urandom(), 1'b1);
      else if (kind < 81) put_item(TAG_REPORT_ID, TYPE_GLOBAL, $urandom(), 1'b1);
      else if (kind < 86) begin
        case ($urandom_range(0, 3))
          0:       put_item(TAG_OUTPUT, TYPE_MAIN, $urandom_range(0, 255), 1'b0);
          1:       put_item(TAG_COLLECTION, TYPE_MAIN, $urandom_range(0, 255), 1'b0);
          2:       put_item(TAG_FEATURE, TYPE_MAIN, $urandom_range(0, 255), 1'b0);
          default: put_item(TAG_END_COLLECTION, TYPE_MAIN, 32'h0, 1'b0);
        endcase
      end
      else if (kind < 91) put_item(4'($urandom()), 2'($urandom()), $urandom(), 1'b1);
      else if (kind < 94) begin
        // long-item prefix, parsed as a reserved short item with two data bytes
        desc_bytes.push_back(pfx(TAG_LONG, TYPE_RESERVED, 2'd2));
        desc_bytes.push_back(8'($urandom()));
        desc_bytes.push_back(8'($urandom()));
        tail_len = 2;
      end
      else if (kind < 97) begin
        // 28 to 40 usages, often more than the list holds
        repeat ($urandom_range(28, 40)) put_item(TAG_USAGE, TYPE_LOCAL, pick_usage(), 1'b0);
      end
      else begin
        desc_bytes.push_back(8'($urandom()));
        tail_len = 0;
      end
    end
    // sometimes the final byte lands inside the last item
    if (tail_len != 0 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, tail_len)) void'(desc_bytes.pop_back());
  endtask

  task automatic send_descriptor();
    int unsigned i;
    logic f;
    for (i = 0; i < desc_bytes.size(); i++) begin
      if (i == 0) f = ($urandom_range(0, 9) != 0);
      else f = ($urandom_range(0, 63) == 0);
      send_byte(desc_bytes[i], f, i == desc_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned quiet_from;
    int unsigned stop_at;
    clear_parse();

    // Keyboard page Input straight out of reset, no first marker
    plan_row(pfx(TAG_USAGE_PAGE, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(PAGE_KEYBOARD[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_INPUT, TYPE_MAIN, 2'd0), 1'b0, 1'b1, 1'b1,
             layout_of(1'b0, NO_FIELD, 16'h0, 32'h0, NO_FIELD, 16'h0, 32'h0, NO_FIELD,
                       8'h00, 1'b1, 8'h00));
    // Pointer X/Y with top report ID and an all-ones 4-byte logical max
    plan_row(pfx(TAG_USAGE_PAGE, TYPE_GLOBAL, 2'd1), 1'b1, 1'b0);
    plan_row(PAGE_DESKTOP[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_REPORT_ID, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(8'hFF, 1'b0, 1'b0);
    plan_row(pfx(TAG_USAGE, TYPE_LOCAL, 2'd1), 1'b0, 1'b0);
    plan_row(USAGE_X[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_USAGE, TYPE_LOCAL, 2'd1), 1'b0, 1'b0);
    plan_row(USAGE_Y[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_LOGICAL_MAX, TYPE_GLOBAL, 2'd3), 1'b0, 1'b0);
    repeat (4) plan_row(8'hFF, 1'b0, 1'b0);
    plan_row(pfx(TAG_REPORT_SIZE, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(8'd16, 1'b0, 1'b0);
    plan_row(pfx(TAG_REPORT_COUNT, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(8'd2, 1'b0, 1'b0);
    plan_row(pfx(TAG_INPUT, TYPE_MAIN, 2'd1), 1'b0, 1'b0);
    plan_row(8'h02, 1'b0, 1'b1, 1'b1,
             layout_of(1'b1, 17'd0, 16'd16, 32'hFFFF_FFFF, 17'd16, 16'd16, 32'hFFFF_FFFF,
                       NO_FIELD, 8'hFF, 1'b0, 8'h00));
    // Button one as tip, Input cut short by the final byte
    plan_row(pfx(TAG_USAGE_PAGE, TYPE_GLOBAL, 2'd1), 1'b1, 1'b0);
    plan_row(PAGE_BUTTON[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_USAGE, TYPE_LOCAL, 2'd1), 1'b0, 1'b0);
    plan_row(USAGE_BUTTON1[7:0], 1'b0, 1'b0);
    plan_row(pfx(TAG_REPORT_SIZE, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(8'd8, 1'b0, 1'b0);
    plan_row(pfx(TAG_REPORT_COUNT, TYPE_GLOBAL, 2'd1), 1'b0, 1'b0);
    plan_row(8'd3, 1'b0, 1'b0);
    plan_row(pfx(TAG_INPUT, TYPE_MAIN, 2'd1), 1'b0, 1'b1, 1'b1,
             layout_of(1'b0, NO_FIELD, 16'h0, 32'h0, NO_FIELD, 16'h0, 32'h0, 17'd0,
                       8'h00, 1'b0, 8'h00));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i])
      send_byte(directed_steps[i].b, directed_steps[i].f, directed_steps[i].l,
                directed_steps[i].lit, directed_steps[i].res);

    // Random descriptors; the tail runs without idling
    stop_at = bytes_sent + RANDOM_BYTES;
    quiet_from = bytes_sent + RANDOM_BYTES * 85 / 100;
    while (bytes_sent < stop_at) begin
      idle_pct = $urandom_range(0, 2) * 20;
      if (bytes_sent >= quiet_from) idle_on = 1'b0;
      build_descriptor();
      send_descriptor();
    end
    in_tvalid <= 1'b0;

    while (expected_layouts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS hid_report_descriptor_parser");
    end else begin
      $display("FAIL hid_report_descriptor_parser");
    end
    $finish;
  end

endmodule
